// ===== sv/yuv420_to_rgb_converter_unit_defines.svh =====
// Assertion macros shared by the checker files of the YUV 4:2:0 to RGB converter.
// Depends on nothing; every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef YUV420_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define YUV420_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define YRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define YRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/yrc_pkg.sv =====
// Shared types and constants of the YUV 4:2:0 to RGB converter.
// Depends on nothing; used by every design module of the block.
`default_nettype none

package yrc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int IMG_W_W = 13;
  localparam int COEF_W  = 48;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 5;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_RED_COEFS   = 2'd1;
  localparam logic [1:0] REG_GREEN_COEFS = 2'd2;
  localparam logic [1:0] REG_BLUE_COEFS  = 2'd3;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 13'd640;
  // Coefficient fields from the top down: v, u, luma.
  localparam logic [COEF_W-1:0] RED_COEFS_RST   = 48'h1895_0000_2A15;
  localparam logic [COEF_W-1:0] GREEN_COEFS_RST = 48'hAFE1_9BB5_2A15;
  localparam logic [COEF_W-1:0] BLUE_COEFS_RST  = 48'h0000_0469_2A15;

  // Offset-removed samples of one pixel.
  typedef struct packed {
    logic signed [8:0] d;
    logic signed [8:0] du;
    logic signed [8:0] dv;
  } diff_t;

endpackage

`default_nettype wire

// ===== sv/yrc_chroma_fetch.sv =====
// Raster position tracking, half-width chroma line store and chroma selection.
// Depends on yrc_pkg for diff_t; feeds yrc_color_calc.
`default_nettype none

module yrc_chroma_fetch #(
  parameter int MAX_WIDTH = yrc_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [yrc_pkg::IMG_W_W-1:0] image_width_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  luma_i,
  input  wire logic [7:0]                  chroma_u_i,
  input  wire logic [7:0]                  chroma_v_i,
  input  wire logic                        frame_start_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output yrc_pkg::diff_t                   diff_o
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_LINE,
    SRC_HOLD
  } src_e;

  logic [COL_W-1:0]  col_q, col_d, col_eff, slot_full;
  logic              odd_q, odd_d, odd_eff;
  logic [31:0]       width_ext, width_eff;
  logic              line_end, slot_ok, even_col, accept;

  logic [15:0]       line_mem [LINE_DEPTH];
  logic [15:0]       rd_q;

  logic              s1_valid_q;
  logic [7:0]        luma_q;
  logic [15:0]       uv_q;
  src_e              src_q, src_d;
  logic [15:0]       cur_q, chroma_sel;

  assign in_ready_o = !s1_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_eff   = frame_start_i ? '0 : col_q;
    odd_eff   = frame_start_i ? 1'b0 : odd_q;
    width_ext = 32'(image_width_i);
    if (width_ext < 32'd2) begin
      width_eff = 32'd2;
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      width_eff = 32'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    line_end  = (32'(col_eff) + 32'd1) >= width_eff;
    col_d     = line_end ? '0 : col_eff + COL_W'(1);
    odd_d     = odd_eff ^ line_end;
    even_col  = !col_eff[0];
    slot_full = col_eff >> 1;
    slot_ok   = 32'(slot_full) < 32'(LINE_DEPTH);
    if (!even_col || !slot_ok) begin
      src_d = SRC_HOLD;
    end else if (odd_eff) begin
      src_d = SRC_LINE;
    end else begin
      src_d = SRC_INPUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      odd_q <= odd_d;
    end
  end

  // An entry is written on an even row and read back on the following odd row, at
  // least a full line later, so a read never overlaps a pending write of the same entry.
  always_ff @(posedge clk_i) begin
    if (accept && src_d == SRC_INPUT) begin
      line_mem[slot_full[SLOT_W-1:0]] <= {chroma_u_i, chroma_v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[slot_full[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      luma_q <= luma_i;
      uv_q   <= {chroma_u_i, chroma_v_i};
      src_q  <= src_d;
    end
  end

  always_comb begin
    unique case (src_q)
      SRC_INPUT: chroma_sel = uv_q;
      SRC_LINE:  chroma_sel = rd_q;
      SRC_HOLD:  chroma_sel = cur_q;
      default:   chroma_sel = cur_q;
    endcase
  end

  // The held chroma follows the pixel that leaves this stage, so odd columns
  // see the chroma of the even column just before them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (s1_valid_q && out_ready_i) begin
      cur_q <= chroma_sel;
    end
  end

  assign out_valid_o = s1_valid_q;
  assign diff_o.d    = $signed({1'b0, luma_q}) - 9'sd16;
  assign diff_o.du   = $signed({1'b0, chroma_sel[15:8]}) - 9'sd128;
  assign diff_o.dv   = $signed({1'b0, chroma_sel[7:0]}) - 9'sd128;

endmodule

`default_nettype wire

// ===== sv/yrc_color_calc.sv =====
// Coefficient multiply stage and sum, shift, fixed-term add and clamp stage for R, G and B.
// Depends on yrc_pkg for diff_t; its output register drives the result stream.
`default_nettype none

module yrc_color_calc (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [yrc_pkg::COEF_W-1:0] red_coefs_i,
  input  wire logic [yrc_pkg::COEF_W-1:0] green_coefs_i,
  input  wire logic [yrc_pkg::COEF_W-1:0] blue_coefs_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire yrc_pkg::diff_t             diff_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [23:0]                     out_rgb_o
);

  logic [yrc_pkg::COEF_W-1:0] coefs [3];
  logic signed [8:0]          term [3];

  logic                       s2_valid_q;
  logic signed [24:0]         prod_q [3][3];
  yrc_pkg::diff_t             diff_q;

  logic signed [26:0]         sum [3];
  logic signed [12:0]         fix [3];
  logic signed [12:0]         total [3];
  logic [7:0]                 chan [3];

  logic                       out_valid_q;
  logic [23:0]                out_rgb_q;
  logic                       out_en;

  function automatic logic [7:0] clamp8(input logic signed [12:0] t);
    logic [7:0] r;
    priority if (t < 13'sd0) begin
      r = 8'd0;
    end else if (t > 13'sd255) begin
      r = 8'd255;
    end else begin
      r = t[7:0];
    end
    return r;
  endfunction

  assign coefs[0] = red_coefs_i;
  assign coefs[1] = green_coefs_i;
  assign coefs[2] = blue_coefs_i;
  assign term[0]  = diff_i.d;
  assign term[1]  = diff_i.du;
  assign term[2]  = diff_i.dv;

  assign out_en     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s2_valid_q || out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s2_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      diff_q <= diff_i;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[c][k] <= 25'(term[k] * $signed(coefs[c][16*k +: 16]));
        end
      end
    end
  end

  // Fixed shift-add terms: red d+dv+dv/2, green d-dv/2, blue d+2du (halving floors).
  always_comb begin
    fix[0] = 13'(diff_q.d) + 13'(diff_q.dv) + 13'(diff_q.dv >>> 1);
    fix[1] = 13'(diff_q.d) - 13'(diff_q.dv >>> 1);
    fix[2] = 13'(diff_q.d) + 13'(diff_q.du) + 13'(diff_q.du);
    for (int c = 0; c < 3; c++) begin
      sum[c]   = 27'(prod_q[c][0]) + 27'(prod_q[c][1]) + 27'(prod_q[c][2]);
      total[c] = 13'($signed(sum[c][26:16])) + fix[c];
      chan[c]  = clamp8(total[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_rgb_q <= {chan[2], chan[1], chan[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rgb_o   = out_rgb_q;

endmodule

`default_nettype wire

// ===== sv/yuv420_to_rgb_converter_unit.sv =====
// Top level of the YUV 4:2:0 to RGB converter: register port, stream ports and pipeline.
// Depends on yrc_pkg, yrc_chroma_fetch and yrc_color_calc.
`default_nettype none

// Converts a raster-order 4:2:0 pixel stream to 8-bit RGB at one pixel per clock while
// the output is taken. Chroma on the input is used only at even rows and even columns;
// it is stored in a MAX_WIDTH/2 x 16-bit single memory (one write and one registered
// read per cycle) and reused for the odd row. A taken pixel passes the line store read,
// coefficient multiplies, then sum, shift and clamp into the output register. Each stage
// has its own valid bit, so while a result waits on m_axis_tready a new transaction is
// accepted as long as a stage is empty. The line store has no clearing pass after reset;
// an odd-row pixel whose even row was never seen since reset gets undefined chroma.
// Registers lie at byte address 8*index: image width, red, green, blue coefficients.
// They are to be written only while no transaction is in flight.
module yuv420_to_rgb_converter_unit #(
  parameter int MAX_WIDTH = yrc_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,  // luma, chroma_u, chroma_v
  input  wire logic [0:0]                  s_axis_tuser,  // frame_start
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // red, green, blue
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [yrc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [yrc_pkg::DATA_W-1:0]  pwdata,
  output logic [yrc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  logic [yrc_pkg::IMG_W_W-1:0] image_width_q;
  logic [yrc_pkg::COEF_W-1:0]  red_coefs_q, green_coefs_q, blue_coefs_q;
  logic                        cfg_write;
  logic [1:0]                  reg_index;

  logic                        fetch_valid, calc_ready;
  yrc_pkg::diff_t              diff;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= yrc_pkg::IMAGE_WIDTH_RST;
      red_coefs_q   <= yrc_pkg::RED_COEFS_RST;
      green_coefs_q <= yrc_pkg::GREEN_COEFS_RST;
      blue_coefs_q  <= yrc_pkg::BLUE_COEFS_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        yrc_pkg::REG_IMAGE_WIDTH: image_width_q <= pwdata[yrc_pkg::IMG_W_W-1:0];
        yrc_pkg::REG_RED_COEFS:   red_coefs_q   <= pwdata[yrc_pkg::COEF_W-1:0];
        yrc_pkg::REG_GREEN_COEFS: green_coefs_q <= pwdata[yrc_pkg::COEF_W-1:0];
        yrc_pkg::REG_BLUE_COEFS:  blue_coefs_q  <= pwdata[yrc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      yrc_pkg::REG_IMAGE_WIDTH: prdata = yrc_pkg::DATA_W'(image_width_q);
      yrc_pkg::REG_RED_COEFS:   prdata = yrc_pkg::DATA_W'(red_coefs_q);
      yrc_pkg::REG_GREEN_COEFS: prdata = yrc_pkg::DATA_W'(green_coefs_q);
      yrc_pkg::REG_BLUE_COEFS:  prdata = yrc_pkg::DATA_W'(blue_coefs_q);
      default:                  prdata = '0;
    endcase
  end

  yrc_chroma_fetch #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_fetch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .image_width_i (image_width_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .luma_i        (s_axis_tdata[7:0]),
    .chroma_u_i    (s_axis_tdata[15:8]),
    .chroma_v_i    (s_axis_tdata[23:16]),
    .frame_start_i (s_axis_tuser[0]),
    .out_valid_o   (fetch_valid),
    .out_ready_i   (calc_ready),
    .diff_o        (diff)
  );

  yrc_color_calc u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .red_coefs_i   (red_coefs_q),
    .green_coefs_i (green_coefs_q),
    .blue_coefs_i  (blue_coefs_q),
    .in_valid_i    (fetch_valid),
    .in_ready_o    (calc_ready),
    .diff_i        (diff),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_rgb_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/yrc_checker.sv =====
// Port-level checks of the YUV 4:2:0 to RGB converter and their bind to the top level.
// Depends on the macros in yuv420_to_rgb_converter_unit_defines.svh.
`default_nettype none
`include "yuv420_to_rgb_converter_unit_defines.svh"

module yrc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        pready
);

  // A result that is not taken stays and keeps its value.
  `YRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // The input side only backs up when a result is waiting at the output.
  `YRC_ASSERT_SAME(a_ready_when_empty, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

  // With the output draining, each taken transaction reaches the output register.
  `YRC_ASSERT_NEXT(a_latency, s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid, "result missing after three cycles")

  // The register port never inserts wait states.
  `YRC_ASSERT_SAME(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind yuv420_to_rgb_converter_unit yrc_checker u_yrc_checker (.*);

`default_nettype wire
